// File: design/sagd_pkg.sv
// Shared constants and codes for the six-axis gesture detector.
package sagd_pkg;

  localparam int TIMER_BITS = 16;
  localparam int AXIS_BITS  = 16;
  localparam int NUM_AXES   = 6;
  localparam int LEVEL_BITS = 15;
  localparam int WIN_BITS   = 16;
  localparam int KIND_BITS  = 4;
  localparam int MAX_RES    = 3;

  localparam int IN_DATA_BITS  = 104;
  localparam int OUT_DATA_BITS = NUM_AXES * AXIS_BITS;

  // Input modes
  localparam logic [1:0] MODE_AXIS   = 2'd0;
  localparam logic [1:0] MODE_BUTTON = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  // Result kinds
  localparam logic [3:0] EV_MOTION       = 4'd0;
  localparam logic [3:0] EV_PUMP         = 4'd1;
  localparam logic [3:0] EV_TWIST_RIGHT  = 4'd2;
  localparam logic [3:0] EV_DOUBLE_RIGHT = 4'd3;
  localparam logic [3:0] EV_TWIST_LEFT   = 4'd4;
  localparam logic [3:0] EV_DOUBLE_LEFT  = 4'd5;
  localparam logic [3:0] EV_BTN1_DOWN    = 4'd6;
  localparam logic [3:0] EV_BTN1_UP      = 4'd7;
  localparam logic [3:0] EV_BTN2_DOWN    = 4'd8;
  localparam logic [3:0] EV_BTN2_UP      = 4'd9;

  // Configuration register indexes
  localparam logic [2:0] REG_PRESS       = 3'd0;
  localparam logic [2:0] REG_RELEASE     = 3'd1;
  localparam logic [2:0] REG_TWIST_ARM   = 3'd2;
  localparam logic [2:0] REG_TWIST_REL   = 3'd3;
  localparam logic [2:0] REG_PUMP_WIN    = 3'd4;
  localparam logic [2:0] REG_DOUBLE_WIN  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [LEVEL_BITS-1:0] PRESS_RST      = 15'd185;
  localparam logic [LEVEL_BITS-1:0] RELEASE_RST    = 15'd40;
  localparam logic [LEVEL_BITS-1:0] TWIST_ARM_RST  = 15'd130;
  localparam logic [LEVEL_BITS-1:0] TWIST_REL_RST  = 15'd75;
  localparam logic [WIN_BITS-1:0]   PUMP_WIN_RST   = 16'd350;
  localparam logic [WIN_BITS-1:0]   DOUBLE_WIN_RST = 16'd300;

  typedef logic [KIND_BITS-1:0] kind_t;
  typedef logic [TIMER_BITS-1:0] timer_t;

endpackage

// File: design/six_axis_gesture_detector.sv
// Six-axis gesture detector: pump, twist, double twist, button edges and motion.
// An input item passes the input register, then the result buffer, before its first result leaves.
// Throughput: one input transaction per cycle while each item yields at most one result
//   and m_tready is high; an item with n results (at most 3) holds the buffer until all leave,
//   setting the rate. Items with no result (ticks, quiet button reports, unused mode) also pass.
// Reset (rst, synchronous): clears gesture state, timers and pipeline; config returns to defaults.
module six_axis_gesture_detector (
  input  logic         clk,
  input  logic         rst,
  // configuration write port
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata, low bit up: move_x, move_y, move_z, turn_x, turn_y, turn_z, button_bits, zero pad
  input  logic [103:0] s_tdata,
  // s_tuser: mode
  input  logic [1:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata, low bit up: out_move_x, out_move_y, out_move_z, out_turn_x, out_turn_y, out_turn_z
  output logic [95:0]  m_tdata,
  // m_tuser: event_kind
  output logic [3:0]   m_tuser,
  output logic         m_tlast
);

  localparam int AB = sagd_pkg::AXIS_BITS;
  localparam int TB = sagd_pkg::TIMER_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [sagd_pkg::LEVEL_BITS-1:0] press_level, release_level;
  logic [sagd_pkg::LEVEL_BITS-1:0] twist_arm_level, twist_release_level;
  logic [sagd_pkg::WIN_BITS-1:0]   pump_window, double_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_level         <= sagd_pkg::PRESS_RST;
      release_level       <= sagd_pkg::RELEASE_RST;
      twist_arm_level     <= sagd_pkg::TWIST_ARM_RST;
      twist_release_level <= sagd_pkg::TWIST_REL_RST;
      pump_window         <= sagd_pkg::PUMP_WIN_RST;
      double_window       <= sagd_pkg::DOUBLE_WIN_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        sagd_pkg::REG_PRESS:      press_level         <= cfg_data[14:0];
        sagd_pkg::REG_RELEASE:    release_level       <= cfg_data[14:0];
        sagd_pkg::REG_TWIST_ARM:  twist_arm_level     <= cfg_data[14:0];
        sagd_pkg::REG_TWIST_REL:  twist_release_level <= cfg_data[14:0];
        sagd_pkg::REG_PUMP_WIN:   pump_window         <= cfg_data;
        sagd_pkg::REG_DOUBLE_WIN: double_window       <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: one stage that holds the accepted transaction
  // ---------------------------------------------------------------------------
  logic        st_valid;
  logic [1:0]  st_mode;
  logic [97:0] st_data;

  // Result buffer: up to three kinds for one item, plus the axis values for motion
  logic [1:0]            res_cnt;
  logic [1:0]            res_idx;
  sagd_pkg::kind_t       res_kind [sagd_pkg::MAX_RES];
  logic [95:0]           res_axes;

  logic buf_free;
  logic advance;

  // The buffer can take a new item when empty or when its final result leaves now.
  assign buf_free = (res_cnt == 2'd0) || (m_tready && (res_idx == res_cnt - 2'd1));
  assign advance  = st_valid && buf_free;
  assign s_tready = !st_valid || buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      st_valid <= 1'b1;
    end else if (advance) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st_mode <= s_tuser;
      st_data <= s_tdata[97:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Gesture state
  // ---------------------------------------------------------------------------
  logic pushed_down, right_armed, left_armed;
  logic right_window_open, left_window_open;
  logic [1:0] buttons_held;
  sagd_pkg::timer_t pump_timer, right_timer, left_timer;

  logic pushed_down_next, right_armed_next, left_armed_next;
  logic right_window_open_next, left_window_open_next;
  logic [1:0] buttons_held_next;
  sagd_pkg::timer_t pump_timer_next, right_timer_next, left_timer_next;

  sagd_pkg::kind_t lst [sagd_pkg::MAX_RES];
  logic [1:0]      lst_n;

  logic signed [AB:0] z_ext, rz_ext;
  logic signed [AB:0] press_s, rel_s, arm_s, trel_s;
  logic pump_ev, right_ev, left_ev;
  sagd_pkg::kind_t right_kind, left_kind;

  // Saturating tick count
  function automatic sagd_pkg::timer_t bump(input sagd_pkg::timer_t t);
    return (t == {TB{1'b1}}) ? t : t + 1'b1;
  endfunction

  always_comb begin
    pushed_down_next       = pushed_down;
    right_armed_next       = right_armed;
    left_armed_next        = left_armed;
    right_window_open_next = right_window_open;
    left_window_open_next  = left_window_open;
    buttons_held_next      = buttons_held;
    pump_timer_next        = pump_timer;
    right_timer_next       = right_timer;
    left_timer_next        = left_timer;
    pump_ev    = 1'b0;
    right_ev   = 1'b0;
    left_ev    = 1'b0;
    right_kind = sagd_pkg::EV_TWIST_RIGHT;
    left_kind  = sagd_pkg::EV_TWIST_LEFT;
    lst[0] = sagd_pkg::EV_MOTION;
    lst[1] = sagd_pkg::EV_MOTION;
    lst[2] = sagd_pkg::EV_MOTION;
    lst_n  = 2'd0;

    z_ext   = {st_data[3*AB-1], st_data[3*AB-1:2*AB]};
    rz_ext  = {st_data[6*AB-1], st_data[6*AB-1:5*AB]};
    press_s = {2'b00, press_level};
    rel_s   = {2'b00, release_level};
    arm_s   = {2'b00, twist_arm_level};
    trel_s  = {2'b00, twist_release_level};

    case (st_mode)
      sagd_pkg::MODE_AXIS: begin
        // Pump: press then release, in that order
        if (z_ext > press_s && !pushed_down_next) begin
          pushed_down_next = 1'b1;
          pump_timer_next  = '0;
        end
        if (z_ext < rel_s && pushed_down_next) begin
          pushed_down_next = 1'b0;
          pump_ev = 32'(pump_timer_next) < 32'(pump_window);
        end

        // Right twist: arm, fire on return, then check for a double
        if (rz_ext > arm_s) right_armed_next = 1'b1;
        if (right_armed_next && rz_ext < trel_s) begin
          right_ev               = 1'b1;
          right_kind             = sagd_pkg::EV_TWIST_RIGHT;
          right_timer_next       = '0;
          right_window_open_next = 1'b1;
          right_armed_next       = 1'b0;
        end
        if (right_window_open_next && right_armed_next) begin
          right_window_open_next = 1'b0;
          if (32'(right_timer_next) < 32'(double_window)) begin
            right_ev         = 1'b1;
            right_kind       = sagd_pkg::EV_DOUBLE_RIGHT;
            right_armed_next = 1'b0;
          end
        end

        // Left twist mirrors the right side on negated levels
        if (rz_ext < -arm_s) left_armed_next = 1'b1;
        if (left_armed_next && rz_ext > -trel_s) begin
          left_ev               = 1'b1;
          left_kind             = sagd_pkg::EV_TWIST_LEFT;
          left_timer_next       = '0;
          left_window_open_next = 1'b1;
          left_armed_next       = 1'b0;
        end
        if (left_window_open_next && left_armed_next) begin
          left_window_open_next = 1'b0;
          if (32'(left_timer_next) < 32'(double_window)) begin
            left_ev         = 1'b1;
            left_kind       = sagd_pkg::EV_DOUBLE_LEFT;
            left_armed_next = 1'b0;
          end
        end

        // Build the result list; drop the left event when pump and right both fired
        if (pump_ev) begin
          lst[lst_n] = sagd_pkg::EV_PUMP;
          lst_n = lst_n + 2'd1;
        end
        if (right_ev) begin
          lst[lst_n] = right_kind;
          lst_n = lst_n + 2'd1;
        end
        if (left_ev && lst_n < 2'd2) begin
          lst[lst_n] = left_kind;
          lst_n = lst_n + 2'd1;
        end
        lst[lst_n] = sagd_pkg::EV_MOTION;
        lst_n = lst_n + 2'd1;
      end
      sagd_pkg::MODE_BUTTON: begin
        if (st_data[96] != buttons_held[0]) begin
          lst[lst_n] = st_data[96] ? sagd_pkg::EV_BTN1_DOWN : sagd_pkg::EV_BTN1_UP;
          lst_n = lst_n + 2'd1;
          buttons_held_next[0] = st_data[96];
        end
        if (st_data[97] != buttons_held[1]) begin
          lst[lst_n] = st_data[97] ? sagd_pkg::EV_BTN2_DOWN : sagd_pkg::EV_BTN2_UP;
          lst_n = lst_n + 2'd1;
          buttons_held_next[1] = st_data[97];
        end
      end
      sagd_pkg::MODE_TICK: begin
        pump_timer_next  = bump(pump_timer);
        right_timer_next = bump(right_timer);
        left_timer_next  = bump(left_timer);
      end
      default: ;
    endcase
  end

  // Commit state when the staged item moves into the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      pushed_down       <= 1'b0;
      right_armed       <= 1'b0;
      left_armed        <= 1'b0;
      right_window_open <= 1'b0;
      left_window_open  <= 1'b0;
      buttons_held      <= 2'b00;
      pump_timer        <= '0;
      right_timer       <= '0;
      left_timer        <= '0;
    end else if (advance) begin
      pushed_down       <= pushed_down_next;
      right_armed       <= right_armed_next;
      left_armed        <= left_armed_next;
      right_window_open <= right_window_open_next;
      left_window_open  <= left_window_open_next;
      buttons_held      <= buttons_held_next;
      pump_timer        <= pump_timer_next;
      right_timer       <= right_timer_next;
      left_timer        <= left_timer_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: while m_tready is high, serialize one result per cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
      res_idx <= 2'd0;
    end else if (advance) begin
      res_cnt <= lst_n;
      res_idx <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      if (res_idx == res_cnt - 2'd1) begin
        res_cnt <= 2'd0;
        res_idx <= 2'd0;
      end else begin
        res_idx <= res_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_kind[0] <= lst[0];
      res_kind[1] <= lst[1];
      res_kind[2] <= lst[2];
      res_axes    <= st_data[95:0];
    end
  end

  sagd_pkg::kind_t cur_kind;

  always_comb begin
    case (res_idx)
      2'd0:    cur_kind = res_kind[0];
      2'd1:    cur_kind = res_kind[1];
      default: cur_kind = res_kind[2];
    endcase
  end

  assign m_tvalid = (res_cnt != 2'd0);
  assign m_tuser  = cur_kind;
  assign m_tlast  = (res_idx == res_cnt - 2'd1);
  // Axis values only travel with the motion result
  assign m_tdata  = (cur_kind == sagd_pkg::EV_MOTION) ? res_axes : '0;

endmodule

// File: sim/six_axis_gesture_detector_check.sv
`timescale 1ns / 100ps
// Checker for the six-axis gesture detector: predicts results and compares the result stream.
module six_axis_gesture_detector_check (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,
  input  logic [3:0]   m_tuser,
  input  logic         m_tlast,
  output int           misfits,
  output int           results_due
);

  localparam int AB     = sagd_pkg::AXIS_BITS;
  localparam int NAX    = sagd_pkg::NUM_AXES;
  localparam int LB     = sagd_pkg::LEVEL_BITS;

  typedef logic [NAX-1:0][AB-1:0] axes_t;

  typedef struct {
    sagd_pkg::kind_t kind;
    axes_t           axes;
    logic            last;
  } gesture_result_t;

  gesture_result_t gesture_results_due [$];

  // Register copies
  logic [LB-1:0]                 press_lvl, release_lvl, arm_lvl, twist_rel_lvl;
  logic [sagd_pkg::WIN_BITS-1:0] pump_win, double_win;

  // Gesture state
  logic             pushed, r_armed, l_armed, r_open, l_open;
  logic [1:0]       held;
  sagd_pkg::timer_t pump_t, right_t, left_t;

  function automatic string axis_field(input int i);
    case (i)
      0:       return "out_move_x";
      1:       return "out_move_y";
      2:       return "out_move_z";
      3:       return "out_turn_x";
      4:       return "out_turn_y";
      default: return "out_turn_z";
    endcase
  endfunction

  task automatic flag_mismatch(input string field, input int expd, input int got);
    $error("%s: expected %0d, got %0d", field, expd, got);
    misfits++;
  endtask

  task automatic detect_gestures(input logic [1:0] mode, input axes_t ax, input logic [1:0] btn);
    int              z, rz, arm, rel;
    sagd_pkg::kind_t kinds [$];
    gesture_result_t r;
    z   = $signed(ax[2]);
    rz  = $signed(ax[5]);
    arm = int'(arm_lvl);
    rel = int'(twist_rel_lvl);
    case (mode)
      sagd_pkg::MODE_AXIS: begin
        if (z > int'(press_lvl) && !pushed) begin
          pushed = 1'b1;
          pump_t = '0;
        end
        if (z < int'(release_lvl) && pushed) begin
          pushed = 1'b0;
          if (pump_t < pump_win) kinds.push_back(sagd_pkg::EV_PUMP);
        end
        if (rz > arm) r_armed = 1'b1;
        if (r_armed && rz < rel) begin
          kinds.push_back(sagd_pkg::EV_TWIST_RIGHT);
          right_t = '0;
          r_open  = 1'b1;
          r_armed = 1'b0;
        end
        if (r_open && r_armed) begin
          r_open = 1'b0;
          if (right_t < double_win) begin
            kinds.push_back(sagd_pkg::EV_DOUBLE_RIGHT);
            r_armed = 1'b0;
          end
        end
        // Left side drops its report once two results are already queued
        if (rz < -arm) l_armed = 1'b1;
        if (l_armed && rz > -rel) begin
          if (kinds.size() < 2) kinds.push_back(sagd_pkg::EV_TWIST_LEFT);
          left_t  = '0;
          l_open  = 1'b1;
          l_armed = 1'b0;
        end
        if (l_open && l_armed) begin
          l_open = 1'b0;
          if (left_t < double_win) begin
            if (kinds.size() < 2) kinds.push_back(sagd_pkg::EV_DOUBLE_LEFT);
            l_armed = 1'b0;
          end
        end
        kinds.push_back(sagd_pkg::EV_MOTION);
      end
      sagd_pkg::MODE_BUTTON: begin
        if (btn[0] != held[0]) begin
          kinds.push_back(btn[0] ? sagd_pkg::EV_BTN1_DOWN : sagd_pkg::EV_BTN1_UP);
          held[0] = btn[0];
        end
        if (btn[1] != held[1]) begin
          kinds.push_back(btn[1] ? sagd_pkg::EV_BTN2_DOWN : sagd_pkg::EV_BTN2_UP);
          held[1] = btn[1];
        end
      end
      sagd_pkg::MODE_TICK: begin
        if (pump_t != '1) pump_t = pump_t + 1'b1;
        if (right_t != '1) right_t = right_t + 1'b1;
        if (left_t != '1) left_t = left_t + 1'b1;
      end
      default: ;
    endcase
    foreach (kinds[i]) begin
      r.kind = kinds[i];
      r.axes = (kinds[i] == sagd_pkg::EV_MOTION) ? ax : '0;
      r.last = (i == kinds.size() - 1);
      gesture_results_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    gesture_result_t want;
    if (rst) begin
      press_lvl     = sagd_pkg::PRESS_RST;
      release_lvl   = sagd_pkg::RELEASE_RST;
      arm_lvl       = sagd_pkg::TWIST_ARM_RST;
      twist_rel_lvl = sagd_pkg::TWIST_REL_RST;
      pump_win      = sagd_pkg::PUMP_WIN_RST;
      double_win    = sagd_pkg::DOUBLE_WIN_RST;
      pushed  = 1'b0;
      r_armed = 1'b0;
      l_armed = 1'b0;
      r_open  = 1'b0;
      l_open  = 1'b0;
      held    = 2'b00;
      pump_t  = '0;
      right_t = '0;
      left_t  = '0;
      gesture_results_due.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          sagd_pkg::REG_PRESS:      press_lvl     = cfg_data[LB-1:0];
          sagd_pkg::REG_RELEASE:    release_lvl   = cfg_data[LB-1:0];
          sagd_pkg::REG_TWIST_ARM:  arm_lvl       = cfg_data[LB-1:0];
          sagd_pkg::REG_TWIST_REL:  twist_rel_lvl = cfg_data[LB-1:0];
          sagd_pkg::REG_PUMP_WIN:   pump_win      = cfg_data;
          sagd_pkg::REG_DOUBLE_WIN: double_win    = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        detect_gestures(s_tuser, s_tdata[NAX*AB-1:0], s_tdata[NAX*AB +: 2]);
      if (m_tvalid && m_tready) begin
        if (gesture_results_due.size() == 0) begin
          $error("unexpected result: event_kind %0d", m_tuser);
          misfits++;
        end else begin
          want = gesture_results_due.pop_front();
          if (m_tuser !== want.kind) flag_mismatch("event_kind", want.kind, m_tuser);
          for (int i = 0; i < NAX; i++)
            if (m_tdata[i*AB +: AB] !== want.axes[i])
              flag_mismatch(axis_field(i), $signed(want.axes[i]),
                            $signed(m_tdata[i*AB +: AB]));
          if (m_tlast !== want.last) flag_mismatch("last", want.last, m_tlast);
        end
      end
    end
    results_due = gesture_results_due.size();
  end

endmodule

// File: sim/six_axis_gesture_detector_tb.sv
`timescale 1ns / 100ps
// Testbench top for the six-axis gesture detector: stimulus, stalls, watchdog and verdict.
module six_axis_gesture_detector_tb;

  localparam int         IDLE_LIMIT    = 2000;  // cycles with no transaction before giving up
  localparam int         SETTLE_CYCLES = 4;     // covers the pipeline registers plus margin
  localparam int         FLOOD_HOLD    = 80;    // long receiver hold-off to back up the block
  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam int         NAX           = sagd_pkg::NUM_AXES;

  typedef logic [NAX-1:0][sagd_pkg::AXIS_BITS-1:0] axes_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_wen;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  // s_tdata, low bit up: move_x, move_y, move_z, turn_x, turn_y, turn_z, button_bits, zero pad
  logic [103:0] s_tdata;
  // s_tuser: mode
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // m_tdata, low bit up: out_move_x, out_move_y, out_move_z, out_turn_x, out_turn_y, out_turn_z
  logic [95:0]  m_tdata;
  // m_tuser: event_kind
  logic [3:0]   m_tuser;
  logic         m_tlast;

  int   misfits;
  int   results_due;
  logic flood_req;

  // Current register settings, mirrored here to aim stimulus at the thresholds
  int lv_press, lv_release, lv_arm, lv_trel, lv_pwin, lv_dwin;
  int burst_left;
  int items_sent;
  int idle_cycles;

  always #6 clk = ~clk;

  six_axis_gesture_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  six_axis_gesture_detector_check i_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .misfits     (misfits),
    .results_due (results_due)
  );

  // Saturate to the 16-bit signed axis range
  function automatic logic [15:0] clip(input int v);
    int c;
    c = v;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return c[15:0];
  endfunction

  // Land a few counts either side of a threshold
  function automatic int near(input int lvl);
    return lvl + int'($urandom_range(0, 6)) - 3;
  endfunction

  function automatic int quiet_val();
    return int'($urandom_range(0, 200)) - 100;
  endfunction

  function automatic axes_t rand_axes();
    axes_t ax;
    for (int i = 0; i < NAX; i++) ax[i] = 16'($urandom_range(0, 65535));
    return ax;
  endfunction

  // Offer one item; return at the edge that takes the transaction.
  // Bursts of random length, separated by random gaps with tvalid low.
  task automatic send_raw(input logic [1:0] mode, input axes_t ax, input logic [1:0] btn);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {6'b0, btn, ax};
    do @(posedge clk); while (!s_tready);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // Axis report with chosen Z translation and Z rotation, other axes random
  task automatic send_axis(input int z, input int rz);
    axes_t ax;
    ax    = rand_axes();
    ax[2] = clip(z);
    ax[5] = clip(rz);
    send_raw(sagd_pkg::MODE_AXIS, ax, 2'($urandom_range(0, 3)));
  endtask

  task automatic send_buttons(input logic [1:0] btn);
    send_raw(sagd_pkg::MODE_BUTTON, rand_axes(), btn);
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_raw(sagd_pkg::MODE_TICK, rand_axes(), 2'($urandom_range(0, 3)));
  endtask

  // Drop tvalid and hold until every predicted result has come out, then let the
  // pipeline empty of items that produce nothing.
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input int val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    @(posedge clk);
  endtask

  // Write all six registers on consecutive edges; call only while idle
  task automatic set_levels(input int p, input int r, input int a, input int t,
                            input int pw, input int dw);
    put_reg(sagd_pkg::REG_PRESS, p);
    put_reg(sagd_pkg::REG_RELEASE, r);
    put_reg(sagd_pkg::REG_TWIST_ARM, a);
    put_reg(sagd_pkg::REG_TWIST_REL, t);
    put_reg(sagd_pkg::REG_PUMP_WIN, pw);
    put_reg(sagd_pkg::REG_DOUBLE_WIN, dw);
    cfg_wen    <= 1'b0;
    lv_press   = p;
    lv_release = r;
    lv_arm     = a;
    lv_trel    = t;
    lv_pwin    = pw;
    lv_dwin    = dw;
  endtask

  // Push down, wait some ticks around the window, let go
  task automatic pump_stroke();
    int n;
    n = (lv_pwin + 2 < 12) ? lv_pwin + 2 : 12;
    send_axis(near(lv_press) + 1, quiet_val());
    send_ticks($urandom_range(0, n));
    send_axis(near(lv_release) - 1, quiet_val());
  endtask

  // Arm, release, wait, re-arm (double twist candidate), maybe release again
  task automatic twist_stroke(input bit left);
    int s, n;
    s = left ? -1 : 1;
    n = (lv_dwin + 2 < 10) ? lv_dwin + 2 : 10;
    send_axis(quiet_val(), s * (near(lv_arm) + 2));
    send_axis(quiet_val(), s * (near(lv_trel) - 2));
    send_ticks($urandom_range(0, n));
    send_axis(quiet_val(), s * (near(lv_arm) + 2));
    if ($urandom_range(0, 1)) send_axis(quiet_val(), s * (near(lv_trel) - 2));
  endtask

  // Mostly well-formed gesture strokes with random content, the rest noise
  task automatic random_traffic(input int n);
    int target, pick;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)      pump_stroke();
      else if (pick < 55) twist_stroke(1'($urandom_range(0, 1)));
      else if (pick < 70) send_buttons(2'($urandom_range(0, 3)));
      else if (pick < 82) send_ticks($urandom_range(1, 5));
      else                send_raw(2'($urandom_range(0, 3)), rand_axes(),
                                   2'($urandom_range(0, 3)));
    end
  endtask

  // Result sink: segments of random stall density, including stall-free ones,
  // plus one long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int seg_left;
    int stall_pct;
    bit flood_seen;
    seg_left   = 0;
    stall_pct  = 0;
    flood_seen = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (flood_req && !flood_seen) begin
        flood_seen = 1;
        m_tready <= 1'b0;
        repeat (FLOOD_HOLD) @(posedge clk);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 40);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      seg_left--;
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_wen || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL six_axis_gesture_detector");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_index <= sagd_pkg::REG_PRESS;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= sagd_pkg::MODE_AXIS;
    flood_req <= 1'b0;
    burst_left  = 0;
    items_sent  = 0;
    lv_press    = int'(sagd_pkg::PRESS_RST);
    lv_release  = int'(sagd_pkg::RELEASE_RST);
    lv_arm      = int'(sagd_pkg::TWIST_ARM_RST);
    lv_trel     = int'(sagd_pkg::TWIST_REL_RST);
    lv_pwin     = int'(sagd_pkg::PUMP_WIN_RST);
    lv_dwin     = int'(sagd_pkg::DOUBLE_WIN_RST);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: button edges, quiet button report, unused mode, tick
    send_buttons(2'b00);
    send_buttons(2'b11);
    send_buttons(2'b01);
    send_buttons(2'b10);
    send_buttons(2'b00);
    send_raw(MODE_UNUSED, '1, 2'b11);
    send_ticks(1);
    // Axis extremes: most negative arms left, most positive pushes, arms right, fires left
    send_raw(sagd_pkg::MODE_AXIS, {NAX{16'h8000}}, 2'b00);
    send_raw(sagd_pkg::MODE_AXIS, {NAX{16'h7FFF}}, 2'b11);
    // Pump plus right twist, then double right and double left
    send_axis(0, 0);
    send_axis(0, 200);
    send_axis(0, -200);

    random_traffic(20);

    // Tight windows so the timers decide both ways
    drain();
    set_levels(100, 50, 60, 20, 4, 3);
    random_traffic(20);

    // Low and high extremes: release above press and twist release above arm
    drain();
    set_levels(0, 32767, 0, 32767, 0, 0);
    send_axis(1, 1);
    send_axis(-1, -1);
    random_traffic(10);

    // Gesture overflow: pump, right twist and left twist in one report drops the left one
    drain();
    set_levels(100, 40, 100, 300, 350, 300);
    send_axis(300, -400);
    send_axis(0, 200);
    // Hold off the receiver for a long stretch while the sender keeps offering
    flood_req  <= 1'b1;
    burst_left = 20;
    random_traffic(15);
    flood_req  <= 1'b0;

    // Highest press and arm levels, lowest release levels and widest windows
    drain();
    set_levels(32767, 0, 32767, 0, 65535, 65535);
    random_traffic(8);

    // Timers run past short windows: no pump and no double twist once a window is reached
    drain();
    set_levels(185, 40, 130, 75, 4, 4);
    send_axis(300, 200);
    send_axis(100, 0);
    send_axis(100, -200);
    send_axis(100, 0);
    send_ticks(4);
    send_axis(0, 200);
    send_axis(100, -200);
    send_axis(100, 0);

    // Random settings
    drain();
    set_levels($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 600),
               $urandom_range(0, 600), $urandom_range(0, 20), $urandom_range(0, 20));
    random_traffic(12);

    drain();
    if (misfits == 0) begin
      $display("PASS six_axis_gesture_detector");
    end else begin
      $display("FAIL six_axis_gesture_detector");
    end
    $finish;
  end

endmodule
